// ----- design/miss_pkg.sv -----
`default_nettype none

package miss_pkg;

  // Field widths of one input item and one result item.
  localparam int TIME_W    = 48;
  localparam int SRC_W     = 3;
  localparam int INST_W    = 3;
  localparam int CH_INST_W = 4;
  localparam int PAYLOAD_W = 64;
  localparam int TIMEOUT_W = 32;

  localparam int IN_FIELDS_W  = TIME_W + TIME_W + SRC_W + INST_W + PAYLOAD_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + 1 + SRC_W + CH_INST_W + PAYLOAD_W + TIME_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = TIMEOUT_W;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 1'b1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd500000;

  // Source codes.
  localparam logic [SRC_W-1:0] SRC_UNKNOWN    = 3'd0;
  localparam logic [SRC_W-1:0] SRC_RADIO      = 3'd1;
  localparam logic [SRC_W-1:0] SRC_LINK_FIRST = 3'd2;
  localparam logic [SRC_W-1:0] SRC_LINK_LAST  = 3'd7;

  // Instance code reported when nothing is chosen.
  localparam logic signed [CH_INST_W-1:0] INST_NONE = -4'sd1;

  typedef enum logic [1:0] {
    MODE_RADIO = 2'd0,
    MODE_LINK  = 2'd1,
    MODE_ANY   = 2'd2,
    MODE_FIRST = 2'd3
  } mode_t;

  // True when a source code is allowed under the given mode.
  function automatic logic source_fits(input mode_t mode, input logic [SRC_W-1:0] first_src,
                                       input logic [SRC_W-1:0] src);
    logic fits;
    case (mode)
      MODE_RADIO: fits = (src == SRC_RADIO);
      MODE_LINK:  fits = (src >= SRC_LINK_FIRST) && (src <= SRC_LINK_LAST);
      MODE_ANY:   fits = 1'b1;
      MODE_FIRST: fits = (first_src == SRC_UNKNOWN) || (src == first_src);
      default:    fits = 1'b0;
    endcase
    return fits;
  endfunction

endpackage

`default_nettype wire

// ----- design/manual_input_source_selector.sv -----
`default_nettype none

// Manual-control input source selector.
// Items enter on the s_ channel, each offering one sample with its time stamps,
// source code, instance number and stick payload. For every item exactly one
// result item leaves on the m_ channel: whether the offered sample was taken,
// and the input that is chosen after it (source, instance, payload, stamp).
// The cfg_ port writes timeout_us (index 0) and source_mode (index 1); the user
// must write it only while no item is in flight; the block does not enforce this.
// An item is registered in the input register and moves on to the result register
// once that register is free; m_tvalid is driven from the result register.
// Throughput is one item per cycle while the receiver does not stall; the single
// pass through two age comparators and the source check, which read and update
// the chosen-input state in the same cycle, sets it.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more; after that s_tready falls until m_tready
// returns. Synchronous reset empties both registers, clears the chosen input,
// forgets the first source and restores timeout 500000 us and radio-only mode.
module manual_input_source_selector (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // fields from bit 0 up: now_us, sample_time_us, source_code,
  // instance_number, stick_payload, zero fill
  input  wire logic [miss_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // fields from bit 0 up: taken, chosen_valid, chosen_source,
  // chosen_instance, chosen_payload, chosen_stamp_us, zero fill
  output logic [miss_pkg::OUT_TDATA_W-1:0]        m_tdata,
  input  wire logic                               cfg_wr_en,
  input  wire logic [miss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [miss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import miss_pkg::*;

  // Configuration registers.
  logic [TIMEOUT_W-1:0] timeout_us;
  mode_t                source_mode;

  // Input register.
  logic                 in_valid;
  logic [TIME_W-1:0]    in_now;
  logic [TIME_W-1:0]    in_stime;
  logic [SRC_W-1:0]     in_src;
  logic [INST_W-1:0]    in_inst;
  logic [PAYLOAD_W-1:0] in_payload;

  // Chosen-input state.
  logic                 held_valid;
  logic [SRC_W-1:0]     held_source;
  logic [INST_W-1:0]    held_instance;
  logic [PAYLOAD_W-1:0] held_payload;
  logic [TIME_W-1:0]    held_stamp;
  logic [TIME_W-1:0]    held_sample_time;
  logic [SRC_W-1:0]     first_source;

  // Result register.
  logic                        out_taken;
  logic                        out_chosen_valid;
  logic [SRC_W-1:0]            out_source;
  logic signed [CH_INST_W-1:0] out_instance;
  logic [PAYLOAD_W-1:0]        out_payload;
  logic [TIME_W-1:0]           out_stamp;

  logic move;
  logic held_fresh;
  logic new_fresh;
  logic held_keep;
  logic take;
  logic valid_next;

  // The item in the input register moves on when the result register is free.
  assign move     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us  <= TIMEOUT_RESET;
      source_mode <= MODE_RADIO;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_us  <= cfg_data;
        REG_MODE:    source_mode <= mode_t'(cfg_data[1:0]);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now     <= s_tdata[TIME_W-1:0];
      in_stime   <= s_tdata[2*TIME_W-1:TIME_W];
      in_src     <= s_tdata[2*TIME_W+SRC_W-1:2*TIME_W];
      in_inst    <= s_tdata[2*TIME_W+SRC_W+INST_W-1:2*TIME_W+SRC_W];
      in_payload <= s_tdata[IN_FIELDS_W-1:2*TIME_W+SRC_W+INST_W];
    end
  end

  // Age of the chosen input and of the offered sample, both against this item's time.
  miss_age_check u_held_age (
    .now   (in_now),
    .stamp (held_sample_time),
    .limit (timeout_us),
    .fresh (held_fresh)
  );

  miss_age_check u_new_age (
    .now   (in_now),
    .stamp (in_stime),
    .limit (timeout_us),
    .fresh (new_fresh)
  );

  // The chosen input survives only if it is still fresh and its source still
  // fits the mode. The offered sample then replaces it when it is valid and
  // either nothing survived or it comes from the same source.
  always_comb begin
    held_keep  = held_valid && held_fresh &&
                 source_fits(source_mode, first_source, held_source);
    take       = new_fresh && source_fits(source_mode, first_source, in_src) &&
                 (!held_keep || (in_src == held_source));
    valid_next = held_keep || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      first_source <= SRC_UNKNOWN;
    end else if (move) begin
      held_valid <= valid_next;
      // An unknown source latched here leaves the slot open for a later one.
      if (take && (first_source == SRC_UNKNOWN)) begin
        first_source <= in_src;
      end
    end
  end

  // These fields are only looked at while held_valid is set.
  always_ff @(posedge clk) begin
    if (move && take) begin
      held_source      <= in_src;
      held_instance    <= in_inst;
      held_payload     <= in_payload;
      held_stamp       <= in_now;
      held_sample_time <= in_stime;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // With nothing chosen the result reports zeros and instance -1.
  always_ff @(posedge clk) begin
    if (move) begin
      out_taken        <= take;
      out_chosen_valid <= valid_next;
      if (take) begin
        out_source   <= in_src;
        out_instance <= signed'({1'b0, in_inst});
        out_payload  <= in_payload;
        out_stamp    <= in_now;
      end else if (held_keep) begin
        out_source   <= held_source;
        out_instance <= signed'({1'b0, held_instance});
        out_payload  <= held_payload;
        out_stamp    <= held_stamp;
      end else begin
        out_source   <= SRC_UNKNOWN;
        out_instance <= INST_NONE;
        out_payload  <= '0;
        out_stamp    <= '0;
      end
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_stamp, out_payload,
                    out_instance, out_source, out_chosen_valid, out_taken};

`ifndef NO_ASSERTIONS
  a_taken_means_chosen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_taken |-> out_chosen_valid)
    else $error("taken reported without a chosen input");

  a_none_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_chosen_valid |-> (out_instance == INST_NONE) &&
                                      (out_source == SRC_UNKNOWN) && (out_stamp == '0))
    else $error("result fields not cleared with nothing chosen");

  a_take_sets_held: assert property (@(posedge clk) disable iff (rst)
    move && take |=> held_valid && (held_stamp == $past(in_now)))
    else $error("accepted sample not held");

  a_first_source_sticks: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ($past(first_source) != SRC_UNKNOWN) |-> $stable(first_source))
    else $error("latched first source changed");
`endif

endmodule

`default_nettype wire

// ----- design/miss_age_check.sv -----
`default_nettype none

// A sample is fresh when it is not from the future and its age is below the limit.
module miss_age_check (
  input  wire logic [miss_pkg::TIME_W-1:0]    now,
  input  wire logic [miss_pkg::TIME_W-1:0]    stamp,
  input  wire logic [miss_pkg::TIMEOUT_W-1:0] limit,
  output logic                                fresh
);
  import miss_pkg::*;

  logic [TIME_W:0] diff;

  // The extra top bit is the borrow: set when the stamp lies ahead of now.
  assign diff  = {1'b0, now} - {1'b0, stamp};
  assign fresh = !diff[TIME_W] &&
                 (diff[TIME_W-1:0] < {{(TIME_W-TIMEOUT_W){1'b0}}, limit});

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

// Self-checking bench for the manual-control input source selector.
// A short directed run walks through the special cases: future samples, the age limit
// at its edge, sources outside the mode, an unknown source being chosen without
// latching, the first-source latch, mode changes that drop the chosen input, a zero
// timeout and the extremes of the time stamps. Random phases follow, each under new
// register values, with samples shaped around the current timeout and sources biased
// toward the chosen one so that the block keeps switching and holding.
module testbench;
  import miss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [TIME_W-1:0] T_MAX = '1;
  localparam logic [PAYLOAD_W-1:0] PAY_ONES = '1;

  // Everything the block reports for one offered sample.
  typedef struct packed {
    logic                 taken;
    logic                 chosen_valid;
    logic [SRC_W-1:0]     source;
    logic [CH_INST_W-1:0] inst;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    stamp;
  } choice_t;

  // Mirror of the selector: its registers, the chosen input and the first-source
  // latch. Every accepted sample produces one expected choice in the queue.
  class selector_scoreboard;
    logic [TIMEOUT_W-1:0] timeout_us;
    mode_t                mode;
    logic                 held_valid;
    logic [SRC_W-1:0]     held_src;
    logic [CH_INST_W-1:0] held_inst;
    logic [PAYLOAD_W-1:0] held_pay;
    logic [TIME_W-1:0]    held_stamp;
    logic [TIME_W-1:0]    held_stime;
    logic [SRC_W-1:0]     first_src;
    choice_t              expected_choices[$];
    int                   errors;
    int                   printed;

    function new();
      timeout_us = TIMEOUT_RESET;
      mode       = MODE_RADIO;
      held_valid = 1'b0;
      held_src   = SRC_UNKNOWN;
      held_inst  = INST_NONE;
      held_pay   = '0;
      held_stamp = '0;
      held_stime = '0;
      first_src  = SRC_UNKNOWN;
      errors     = 0;
      printed    = 0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_TIMEOUT) begin
        timeout_us = val;
      end else begin
        mode = mode_t'(val[1:0]);
      end
    endfunction

    function int pending();
      return expected_choices.size();
    endfunction

    function logic allowed(input logic [SRC_W-1:0] src);
      case (mode)
        MODE_RADIO: return src == SRC_RADIO;
        MODE_LINK:  return (src >= SRC_LINK_FIRST) && (src <= SRC_LINK_LAST);
        MODE_ANY:   return 1'b1;
        default:    return (first_src == SRC_UNKNOWN) || (src == first_src);
      endcase
    endfunction

    // A sample counts when it is not from the future, is younger than the timeout
    // and its source fits the mode.
    function logic fresh(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stime,
                         input logic [SRC_W-1:0] src);
      if (now < stime) return 1'b0;
      if ((now - stime) >= {16'd0, timeout_us}) return 1'b0;
      return allowed(src);
    endfunction

    function void note_offer(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stime,
                             input logic [SRC_W-1:0] src, input logic [INST_W-1:0] inst,
                             input logic [PAYLOAD_W-1:0] pay);
      choice_t c;
      // The chosen input is checked first; only valid and instance are cleared.
      if (!fresh(now, held_stime, held_src)) begin
        held_valid = 1'b0;
        held_inst  = INST_NONE;
      end
      c.taken = 1'b0;
      if (fresh(now, stime, src) && (!held_valid || src == held_src)) begin
        held_valid = 1'b1;
        held_src   = src;
        held_inst  = {1'b0, inst};
        held_pay   = pay;
        held_stamp = now;
        held_stime = stime;
        // An unknown source latches nothing, so a later one still can.
        if (first_src == SRC_UNKNOWN) first_src = src;
        c.taken = 1'b1;
      end
      c.chosen_valid = held_valid;
      if (held_valid) begin
        c.source  = held_src;
        c.inst    = held_inst;
        c.payload = held_pay;
        c.stamp   = held_stamp;
      end else begin
        c.source  = SRC_UNKNOWN;
        c.inst    = INST_NONE;
        c.payload = '0;
        c.stamp   = '0;
      end
      expected_choices.push_back(c);
    endfunction

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      if (printed < 40) begin
        $display("tb: mismatch in %s at %0t: got %h, expected %h", what, $realtime, got, want);
        printed++;
      end
    endtask

    task check_choice(input logic [OUT_TDATA_W-1:0] data);
      choice_t got;
      choice_t want;
      // Result layout from bit 0: taken, chosen_valid, source, instance, payload, stamp.
      got.taken        = data[0];
      got.chosen_valid = data[1];
      got.source       = data[4:2];
      got.inst         = data[8:5];
      got.payload      = data[72:9];
      got.stamp        = data[120:73];
      if (expected_choices.size() == 0) begin
        report("result with nothing expected", 64'(got.taken), 64'd0);
      end else begin
        want = expected_choices.pop_front();
        if (got.taken !== want.taken) report("taken", 64'(got.taken), 64'(want.taken));
        if (got.chosen_valid !== want.chosen_valid)
          report("chosen_valid", 64'(got.chosen_valid), 64'(want.chosen_valid));
        if (got.source !== want.source) report("chosen_source", 64'(got.source), 64'(want.source));
        if (got.inst !== want.inst) report("chosen_instance", 64'(got.inst), 64'(want.inst));
        if (got.payload !== want.payload) report("chosen_payload", got.payload, want.payload);
        if (got.stamp !== want.stamp) report("chosen_stamp_us", 64'(got.stamp), 64'(want.stamp));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = REG_TIMEOUT;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  selector_scoreboard board;
  // When set, neither side idles; one long stretch of the run uses it.
  bit                no_idle = 1'b0;
  logic [TIME_W-1:0] clock_us = '0;
  int unsigned       cycle_count = 0;

  manual_input_source_selector DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver stalls at random except during the calm stretch.
  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  // Every accepted result item is checked against the oldest expected choice.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_choice(m_tdata);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one sample. Called and returning at a falling edge; the sample is noted
  // with the scoreboard at the rising edge where it is accepted.
  task automatic offer(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stime,
                       input logic [SRC_W-1:0] src, input logic [INST_W-1:0] inst,
                       input logic [PAYLOAD_W-1:0] pay);
    while (!no_idle && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({pay, inst, src, stime, now});
    do @(posedge clk); while (!s_tready);
    board.note_offer(now, stime, src, inst, pay);
    @(negedge clk);
  endtask

  // Waits until every expected choice has come out and the two pipeline registers
  // have drained. Returns at a falling edge.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers are only written while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // One random phase under fresh register values. Ages are drawn mostly inside the
  // timeout, some right at its edge, some from the future and some far out; now
  // occasionally jumps anywhere or steps back.
  task automatic run_phase(input logic [TIMEOUT_W-1:0] tmo, input mode_t md, input int count);
    int unsigned       r;
    int unsigned       step;
    logic [63:0]       wide;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] stime;
    logic [SRC_W-1:0]  src;
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_MODE, CFG_DATA_W'(md));
    for (int i = 0; i < count; i++) begin
      wide = {$urandom, $urandom};
      r = $urandom_range(99);
      step = (tmo == 0) ? $urandom_range(1000) : ($urandom % (tmo / 2 + 1));
      if (r < 3) clock_us = wide[TIME_W-1:0];
      else if (r < 6) clock_us = clock_us - TIME_W'($urandom_range(5000));
      else clock_us = clock_us + TIME_W'(step);

      wide = {$urandom, $urandom};
      r = $urandom_range(99);
      if (r < 50) age = (tmo == 0) ? '0 : TIME_W'($urandom % tmo);
      else if (r < 65) age = {16'd0, tmo} + TIME_W'($urandom_range(2)) - TIME_W'(1);
      else if (r < 75) age = -TIME_W'($urandom_range(1, 50));
      else age = wide[TIME_W-1:0];
      stime = (r >= 88) ? wide[TIME_W+15:16] : clock_us - age;

      r = $urandom_range(99);
      if (r < 50 && board.held_valid) begin
        src = board.held_src;
      end else if (r < 80) begin
        case (board.mode)
          MODE_RADIO: src = SRC_RADIO;
          MODE_LINK:  src = SRC_W'($urandom_range(SRC_LINK_FIRST, SRC_LINK_LAST));
          MODE_ANY:   src = SRC_W'($urandom_range(7));
          default:    src = (board.first_src == SRC_UNKNOWN) ? SRC_W'($urandom_range(7))
                                                             : board.first_src;
        endcase
      end else begin
        src = SRC_W'($urandom_range(7));
      end
      offer(clock_us, stime, src, INST_W'($urandom_range(7)), {$urandom, $urandom});
    end
  endtask

  initial begin
    logic [TIMEOUT_W-1:0] tmo;
    mode_t md;
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, radio only: nothing here may be taken, so no source is latched.
    offer(48'd1000, 48'd2000, SRC_RADIO, 3'd0, 64'd0);            // sample from the future
    offer(48'd1000, 48'd1000, SRC_LINK_FIRST, 3'd1, 64'd1);       // link source not allowed
    offer(48'd1000, 48'd1000, SRC_UNKNOWN, 3'd2, 64'd2);          // unknown source not allowed
    offer(T_MAX, 48'd0, SRC_RADIO, 3'd7, PAY_ONES);               // far too old
    offer(48'd600000, 48'd100000, SRC_RADIO, 3'd3, 64'd3);        // age exactly the timeout

    // Any source: an unknown source gets chosen but does not latch.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_ANY));
    offer(48'd1000000, 48'd999000, SRC_UNKNOWN, 3'd5, 64'h1234_5678_9abc_def0);

    // First-source mode: nothing latched yet, so the unknown source still fits.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_FIRST));
    offer(48'd1001000, 48'd1000500, 3'd3, 3'd1, 64'd4);           // other source, not taken
    offer(48'd1001500, 48'd1001000, SRC_UNKNOWN, 3'd2, 64'd5);    // same source, taken
    offer(48'd1600000, 48'd1599999, 3'd3, 3'd4, 64'd6);           // chosen is stale; 3 latches
    offer(48'd1600100, 48'd1600050, SRC_RADIO, 3'd0, 64'd7);      // does not match the latch
    offer(48'd1600200, 48'd1600200, 3'd3, 3'd1, PAY_ONES);

    // Back to radio only: the chosen link input is dropped on the next item.
    write_reg(REG_MODE, CFG_DATA_W'(MODE_RADIO));
    offer(48'd1600300, 48'd1600300, SRC_LINK_LAST, 3'd6, 64'd8);
    offer(48'd1600400, 48'd1600000, SRC_RADIO, 3'd6, 64'd9);
    offer(48'd2100399, 48'd1600400, SRC_RADIO, 3'd7, 64'd10);     // age one below the timeout

    // A zero timeout makes every sample invalid.
    write_reg(REG_TIMEOUT, 32'd0);
    offer(48'd2100500, 48'd2100500, SRC_RADIO, 3'd0, 64'd11);
    offer(48'd2100600, 48'd2100600, SRC_RADIO, 3'd1, 64'd12);

    // Largest timeout, link sources, time stamps at their extremes.
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_LINK));
    offer(T_MAX, T_MAX - 48'hFFFF_FFFE, SRC_LINK_LAST, 3'd7, PAY_ONES);
    offer(T_MAX, 48'd0, SRC_LINK_LAST, 3'd3, 64'd13);
    offer(T_MAX, T_MAX, SRC_LINK_FIRST, 3'd2, 64'd14);
    offer(T_MAX, T_MAX, SRC_LINK_LAST, 3'd0, 64'd0);
    offer(48'd0, 48'd0, SRC_LINK_LAST, 3'd5, 64'd15);            // chosen sample now in the future

    // Random phases; the first four cover every mode with fixed timeouts.
    clock_us = 48'd5000000;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: tmo = 32'd1;
        1: tmo = TIMEOUT_RESET;
        2: tmo = 32'hFFFF_FFFF;
        3: tmo = 32'd0;
        default: begin
          case ($urandom_range(3))
            0: tmo = 32'($urandom_range(2, 2000));
            1: tmo = TIMEOUT_RESET;
            2: tmo = $urandom;
            default: tmo = 32'hFFFF_FFFF;
          endcase
        end
      endcase
      md = (p < 4) ? mode_t'(p) : mode_t'($urandom_range(3));
      no_idle = (p == 5 || p == 6);
      run_phase(tmo, md, (p == 3) ? 20 : 68);
    end
    no_idle = 1'b0;

    settle();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
